// File: hdl/rfid_inv_pkg.sv
// Types and codes shared by the tag inventory state machine.
package rfid_inv_pkg;

   typedef enum logic [2:0] {
      OP_QUERY    = 3'd0,
      OP_QUERYREP = 3'd1,
      OP_QUERYADJ = 3'd2,
      OP_SELECT   = 3'd3,
      OP_ACK      = 3'd4,
      OP_REQRN    = 3'd5,
      OP_READ     = 3'd6,
      OP_NAK      = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      REPLY_NONE   = 3'd0,
      REPLY_RN16   = 3'd1,
      REPLY_EPC    = 3'd2,
      REPLY_HANDLE = 3'd3,
      REPLY_READ   = 3'd4
   } reply_type;

   typedef enum logic [2:0] {
      SA_SET_CLR = 3'd0,
      SA_SET_NOP = 3'd1,
      SA_NOP_CLR = 3'd2,
      SA_NEG_NOP = 3'd3,
      SA_CLR_SET = 3'd4,
      SA_CLR_NOP = 3'd5,
      SA_NOP_SET = 3'd6,
      SA_NOP_NEG = 3'd7
   } sel_action_type;

   typedef enum logic [1:0] {
      CSR_EPC   = 2'd0,
      CSR_TID   = 2'd1,
      CSR_USER  = 2'd2,
      CSR_SHIFT = 2'd3
   } csr_index_type;

   localparam logic [2:0] ST_READY     = 3'd0;
   localparam logic [2:0] ST_ARBITRATE = 3'd1;
   localparam logic [2:0] ST_ACKED     = 3'd3;
   localparam logic [2:0] ST_OPEN      = 3'd4;
   localparam logic [2:0] ST_SECURED   = 3'd5;

   localparam logic [2:0] UPDN_KEEP = 3'd0;
   localparam logic [2:0] UPDN_DOWN = 3'd3;
   localparam logic [2:0] UPDN_UP   = 3'd6;

   localparam logic [1:0] BANK_NONE = 2'd0;
   localparam logic [1:0] BANK_EPC  = 2'd1;
   localparam logic [1:0] BANK_TID  = 2'd2;

   localparam logic [1:0] SEL_NOT_SL = 2'd2;
   localparam logic [1:0] SEL_SL     = 2'd3;

   localparam logic [2:0] TARGET_SL = 3'd4;

   localparam logic [3:0]  Q_MAX      = 4'hF;
   localparam logic [8:0]  TID_LEN    = 9'd24;
   localparam logic [8:0]  USER_LEN   = 9'd8;
   localparam logic [23:0] TID_RESET  = 24'hE20000;
   localparam logic [4:0]  TRCAL_DR8  = 5'd8;
   localparam logic [4:0]  TRCAL_DR21 = 5'd21;

   typedef struct packed {
      logic        pad;
      logic [63:0] mask;
      logic [7:0]  mask_length;
      logic [7:0]  pointer;
      logic [1:0]  membank;
      logic [2:0]  action;
      logic [3:0]  q_in;
      logic [2:0]  target;
      logic [1:0]  session;
      logic [1:0]  sel;
      logic [3:0]  link_bits;
      logic [2:0]  next_state;
   } req_data_type;

   typedef struct packed {
      logic [1:0]  pad;
      logic        pilot_extended;
      logic [3:0]  subcarrier_cycles;
      logic [4:0]  trcal_divide;
      logic [15:0] read_count;
      logic [3:0]  session_flags;
      logic        sl_flag;
      logic [3:0]  q_value;
      logic [15:0] slot_count;
      logic [2:0]  tag_state;
   } rsp_data_type;

endpackage

// File: hdl/rfid_tag_inventory_fsm_top.sv
// Tag-side inventory state machine with input and result registers.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/tready    | tuser opcode, tdata command fields
//  rsp     | out       | rsp_tvalid/tready    | tuser reply kind, tdata tag state
//  csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// Each item is held in the input register and is then evaluated
// combinationally into the result register; one item is taken per cycle
// unless the result is stalled, and the tag state registers update with it.
// Reset clears the tag state and loads the register defaults; no clearing pass.
// A stalled result holds the item in the input register, and input is taken
// again as soon as the result register frees.
module rfid_tag_inventory_fsm_top #(
   parameter int MASK_WIDTH = 64,
   parameter int EPC_WIDTH  = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // next_state, link_bits, sel, session, target, q_in, action, membank,
   // pointer, mask_length, mask, zero pad
   input  rfid_inv_pkg::req_data_type req_tdata,
   // opcode
   input  logic [2:0]                 req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // tag_state, slot_count, q_value, sl_flag, session_flags, read_count,
   // trcal_divide, subcarrier_cycles, pilot_extended, zero pad
   output rfid_inv_pkg::rsp_data_type rsp_tdata,
   // reply_kind
   output logic [2:0]                 rsp_tuser,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [63:0]                csr_data
);
   import rfid_inv_pkg::*;

   localparam int MASK_PAD = 64 - MASK_WIDTH;
   localparam int EPC_PAD  = 64 - EPC_WIDTH;

   logic                  req_valid_ff, req_valid_in;
   opcode_type            req_op_ff;
   logic [2:0]            req_next_ff;
   logic [3:0]            req_link_ff;
   logic [1:0]            req_sel_ff;
   logic [1:0]            req_ses_ff;
   logic [2:0]            req_tgt_ff;
   logic [3:0]            req_q_ff;
   logic [2:0]            req_act_ff;
   logic [1:0]            req_bank_ff;
   logic [7:0]            req_ptr_ff;
   logic [7:0]            req_len_ff;
   logic [MASK_WIDTH-1:0] req_mask_ff;

   logic [EPC_WIDTH-1:0]  epc_ff;
   logic [23:0]           tid_ff;
   logic [7:0]            user_ff;
   logic [3:0]            shift_ff;

   logic [2:0]  st_ff, st_in;
   logic        sl_ff, sl_in;
   logic [3:0]  inv_ff, inv_in;
   logic [1:0]  last_ff, last_in;
   logic [3:0]  q_ff, q_in;
   logic [15:0] slot_ff, slot_in;
   logic        round_ff, round_in;
   logic [15:0] rdc_ff, rdc_in;
   logic [3:0]  link_ff, link_in;
   reply_type   reply_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;
   reply_type    rsp_kind_ff;

   logic        advance;
   logic        access_st;
   logic [3:0]  query_inv;
   logic        sl_ok;
   logic [3:0]  query_slot;
   logic [3:0]  adj_q;
   logic        adj_ok;
   logic [3:0]  adj_slot;

   logic [63:0] sel_data;
   logic [63:0] sel_mask;
   logic [63:0] top_mask;
   logic [7:0]  sel_len;
   logic [8:0]  sel_bank_len;
   logic [7:0]  sel_ptr;
   logic        sel_ignore;
   logic        sel_hit;
   logic        act_set, act_val, act_neg;

   assign advance    = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign req_valid_in = req_tready ? req_tvalid : req_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign access_st = (st_ff == ST_ACKED) || (st_ff == ST_OPEN) || (st_ff == ST_SECURED);
   assign query_inv = (access_st && (req_ses_ff == last_ff))
                      ? (inv_ff ^ (4'b0001 << req_ses_ff)) : inv_ff;
   assign sl_ok     = !req_sel_ff[1] || ((req_sel_ff == SEL_SL) && sl_ff)
                      || ((req_sel_ff == SEL_NOT_SL) && !sl_ff);
   assign query_slot = req_q_ff >> shift_ff;
   assign adj_slot   = adj_q >> shift_ff;

   always_comb begin
      adj_q  = q_ff;
      adj_ok = 1'b1;
      unique case (req_act_ff)
         UPDN_UP:   adj_q = (q_ff == Q_MAX) ? q_ff : q_ff + 4'd1;
         UPDN_DOWN: adj_q = (q_ff == 4'd0) ? q_ff : q_ff - 4'd1;
         UPDN_KEEP: adj_q = q_ff;
         default:   adj_ok = 1'b0;
      endcase
   end

   always_comb begin
      sel_ptr      = req_ptr_ff;
      sel_len      = req_len_ff;
      sel_bank_len = USER_LEN;
      sel_data     = {user_ff, 56'd0};
      sel_ignore   = (req_len_ff == 8'd0) || (req_bank_ff == BANK_NONE)
                     || ({1'b0, req_len_ff} > 9'(MASK_WIDTH));
      priority if (req_bank_ff == BANK_EPC) begin
         sel_bank_len = 9'(EPC_WIDTH);
         sel_data     = (64'(epc_ff) << EPC_PAD) << req_ptr_ff[5:0];
         if ({1'b0, req_ptr_ff} >= 9'(EPC_WIDTH)) begin
            sel_ignore = 1'b1;
         end
      end else if (req_bank_ff == BANK_TID) begin
         sel_bank_len = TID_LEN;
         sel_data     = {tid_ff, 40'd0} << req_ptr_ff[4:0];
         if ({1'b0, req_ptr_ff} >= TID_LEN) begin
            sel_ignore = 1'b1;
         end
      end else begin
         sel_ptr = 8'd0;
         if (req_len_ff > 8'(USER_LEN)) begin
            sel_len = 8'(USER_LEN);
         end
      end
      sel_mask = 64'(req_mask_ff) << MASK_PAD;
      top_mask = ~({64{1'b1}} >> sel_len);
      sel_hit  = (({1'b0, sel_ptr} + {1'b0, sel_len}) <= sel_bank_len)
                 && (((sel_data ^ sel_mask) & top_mask) == 64'd0);
   end

   always_comb begin
      act_set = 1'b0;
      act_val = 1'b0;
      act_neg = 1'b0;
      unique case (sel_action_type'(req_act_ff))
         SA_SET_CLR: begin act_set = 1'b1; act_val = sel_hit; end
         SA_SET_NOP: begin act_set = sel_hit; act_val = 1'b1; end
         SA_NOP_CLR: begin act_set = !sel_hit; act_val = 1'b0; end
         SA_NEG_NOP: act_neg = sel_hit;
         SA_CLR_SET: begin act_set = 1'b1; act_val = !sel_hit; end
         SA_CLR_NOP: begin act_set = sel_hit; act_val = 1'b0; end
         SA_NOP_SET: begin act_set = !sel_hit; act_val = 1'b1; end
         SA_NOP_NEG: act_neg = !sel_hit;
         default:    act_neg = 1'b0;
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      sl_in    = sl_ff;
      inv_in   = inv_ff;
      last_in  = last_ff;
      q_in     = q_ff;
      slot_in  = slot_ff;
      round_in = round_ff;
      rdc_in   = rdc_ff;
      link_in  = link_ff;
      reply_in = REPLY_NONE;
      unique case (req_op_ff)
         OP_QUERY: begin
            link_in = req_link_ff;
            inv_in  = query_inv;
            if (!(sl_ok && (req_tgt_ff[0] == query_inv[req_ses_ff]))) begin
               st_in = ST_READY;
            end else begin
               last_in  = req_ses_ff;
               q_in     = req_q_ff;
               slot_in  = 16'(query_slot);
               round_in = 1'b1;
               if (round_ff || (query_slot == 4'd0)) begin
                  reply_in = REPLY_RN16;
                  st_in    = req_next_ff;
               end else begin
                  st_in = ST_ARBITRATE;
               end
            end
         end
         OP_QUERYREP: begin
            if (access_st) begin
               inv_in = inv_ff ^ (4'b0001 << last_ff);
               st_in  = ST_READY;
            end else begin
               slot_in = slot_ff - 16'd1;
               if (slot_ff != 16'd1) begin
                  st_in = ST_ARBITRATE;
               end else begin
                  reply_in = REPLY_RN16;
                  st_in    = req_next_ff;
               end
            end
         end
         OP_QUERYADJ: begin
            if (req_ses_ff == last_ff) begin
               if (access_st) begin
                  inv_in = inv_ff ^ (4'b0001 << req_ses_ff);
                  st_in  = ST_READY;
               end else if (adj_ok) begin
                  q_in    = adj_q;
                  slot_in = 16'(adj_slot);
                  if (adj_slot == 4'd0) begin
                     reply_in = REPLY_RN16;
                     st_in    = req_next_ff;
                  end else begin
                     st_in = ST_ARBITRATE;
                  end
               end
            end
         end
         OP_SELECT: begin
            if ((req_tgt_ff <= TARGET_SL) && !sel_ignore) begin
               st_in = req_next_ff;
               if (req_tgt_ff == TARGET_SL) begin
                  if (act_set) begin
                     sl_in = act_val;
                  end else if (act_neg) begin
                     sl_in = !sl_ff;
                  end
               end else begin
                  if (act_set) begin
                     inv_in[req_tgt_ff[1:0]] = !act_val;
                  end else if (act_neg) begin
                     inv_in[req_tgt_ff[1:0]] = !inv_ff[req_tgt_ff[1:0]];
                  end
               end
            end
         end
         OP_ACK: begin
            reply_in = REPLY_EPC;
            st_in    = req_next_ff;
         end
         OP_REQRN: begin
            reply_in = REPLY_HANDLE;
            rdc_in   = rdc_ff + 16'd1;
            st_in    = req_next_ff;
         end
         OP_READ: begin
            reply_in = REPLY_READ;
            st_in    = req_next_ff;
         end
         OP_NAK: st_in = req_next_ff;
         default: st_in = st_ff;
      endcase
   end

   always_comb begin
      rsp_data_in                   = '0;
      rsp_data_in.tag_state         = st_in;
      rsp_data_in.slot_count        = slot_in;
      rsp_data_in.q_value           = q_in;
      rsp_data_in.sl_flag           = sl_in;
      rsp_data_in.session_flags     = inv_in;
      rsp_data_in.read_count        = rdc_in;
      rsp_data_in.trcal_divide      = link_in[3] ? TRCAL_DR21 : TRCAL_DR8;
      rsp_data_in.subcarrier_cycles = 4'b0001 << link_in[2:1];
      rsp_data_in.pilot_extended    = link_in[0];
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_op_ff   <= opcode_type'(req_tuser);
         req_next_ff <= req_tdata.next_state;
         req_link_ff <= req_tdata.link_bits;
         req_sel_ff  <= req_tdata.sel;
         req_ses_ff  <= req_tdata.session;
         req_tgt_ff  <= req_tdata.target;
         req_q_ff    <= req_tdata.q_in;
         req_act_ff  <= req_tdata.action;
         req_bank_ff <= req_tdata.membank;
         req_ptr_ff  <= req_tdata.pointer;
         req_len_ff  <= req_tdata.mask_length;
         req_mask_ff <= req_tdata.mask[63 -: MASK_WIDTH];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_kind_ff <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         epc_ff       <= '0;
         tid_ff       <= TID_RESET;
         user_ff      <= 8'd0;
         shift_ff     <= 4'd0;
         st_ff        <= ST_READY;
         sl_ff        <= 1'b0;
         inv_ff       <= 4'd0;
         last_ff      <= 2'd0;
         q_ff         <= 4'd0;
         slot_ff      <= 16'd0;
         round_ff     <= 1'b0;
         rdc_ff       <= 16'd0;
         link_ff      <= 4'd0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index_type'(csr_index))
               CSR_EPC:   epc_ff   <= csr_data[63 -: EPC_WIDTH];
               CSR_TID:   tid_ff   <= csr_data[23:0];
               CSR_USER:  user_ff  <= csr_data[7:0];
               CSR_SHIFT: shift_ff <= csr_data[3:0];
               default:   shift_ff <= shift_ff;
            endcase
         end
         if (advance) begin
            st_ff    <= st_in;
            sl_ff    <= sl_in;
            inv_ff   <= inv_in;
            last_ff  <= last_in;
            q_ff     <= q_in;
            slot_ff  <= slot_in;
            round_ff <= round_in;
            rdc_ff   <= rdc_in;
            link_ff  <= link_in;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   a_rdc_only_reqrn: assert property (@(posedge clock) disable iff (reset)
      !(advance && (req_op_ff == OP_REQRN)) |=> $stable(rdc_ff))
      else $error("read counter changed without a ReqRN item");

   a_round_sticky: assert property (@(posedge clock) disable iff (reset)
      round_ff |=> round_ff)
      else $error("in-round flag cleared outside reset");

   a_rsp_from_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared without an evaluated item");

   a_link_only_query: assert property (@(posedge clock) disable iff (reset)
      !(advance && (req_op_ff == OP_QUERY)) |=> $stable(link_ff))
      else $error("link settings changed without a Query item");

endmodule
